// File: rtl/pjb_pkg.sv
`timescale 1ns / 1ps

package pjb_pkg;

  // store geometry
  localparam int DEPTH = 16384;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths fixed by the interface
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 15;
  localparam int GRACE_W  = 4;
  localparam int CMD_W    = 2;
  localparam int REG_W    = 2;

  // width used to compare the fill count against a level register
  localparam int CMP_W = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PERIOD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PULL   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd3;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_PREBUFFER = 2'd0;
  localparam logic [REG_W-1:0] REG_UNDERRUN  = 2'd1;
  localparam logic [REG_W-1:0] REG_GRACE     = 2'd2;

  // configuration reset values
  localparam logic [LEVEL_W-1:0] PREBUFFER_RST = 15'd4608;
  localparam logic [LEVEL_W-1:0] UNDERRUN_RST  = 15'd1536;
  localparam logic [GRACE_W-1:0] GRACE_RST     = 4'd5;

  // result fields that travel beside the store read
  typedef struct packed {
    logic               from_buffer;
    logic               push_accepted;
    logic [LEVEL_W-1:0] fill_level;
    logic               playing;
    logic [GRACE_W-1:0] grace_count;
  } res_t;

endpackage

// File: rtl/pcm_jitter_buffer.sv
`timescale 1ns / 1ps

// pcm_jitter_buffer: playback buffer for 16-bit PCM samples
//
// input channel (in_valid / in_stall) carries one command per beat: push a
// sample, start a period, pull a sample or flush. every accepted beat gives
// exactly one result beat on the output channel (out_valid / out_stall),
// in order. configuration (prebuffer level, underrun level, grace periods)
// is written over cfg_valid / cfg_ready / cfg_index / cfg_data by the user
// only while idle; the block itself does not enforce this.
//
// a result beat passes the synchronous sample store read, then the output
// register. throughput is one beat per cycle while out_stall is low;
// one write and one read store port; fill/pointer state updates on accept.
//
// reset empties the buffer, closes the playback gate and loads the default
// levels; store contents are left as they are. when the receiver stalls the
// result stays on the output, one more beat is held in the read stage, and
// in_stall rises once both are full.

module pcm_jitter_buffer (
  input  logic                            clk,
  input  logic                            rst,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pjb_pkg::CMD_W-1:0]       cmd,
  input  logic signed [pjb_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                            stream_active,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [pjb_pkg::SAMPLE_W-1:0] sample_out,
  output logic                            from_buffer,
  output logic                            push_accepted,
  output logic [pjb_pkg::LEVEL_W-1:0]     fill_level,
  output logic                            playing,
  output logic [pjb_pkg::GRACE_W-1:0]     grace_count,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pjb_pkg::REG_W-1:0]       cfg_index,
  input  logic [pjb_pkg::LEVEL_W-1:0]     cfg_data
);

  // configuration registers
  logic [pjb_pkg::LEVEL_W-1:0] prebuffer_level;
  logic [pjb_pkg::LEVEL_W-1:0] underrun_level;
  logic [pjb_pkg::GRACE_W-1:0] grace_periods;

  // buffer state
  logic [pjb_pkg::PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [pjb_pkg::PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [pjb_pkg::CNT_W-1:0]   count, count_next;
  logic                        gate, gate_next;
  logic [pjb_pkg::GRACE_W-1:0] under, under_next;

  // sample store and its read data register
  logic signed [pjb_pkg::SAMPLE_W-1:0] store [pjb_pkg::DEPTH];
  logic signed [pjb_pkg::SAMPLE_W-1:0] rdata;

  // pipeline
  logic              accept;
  logic              do_push, do_pull;
  pjb_pkg::res_t     res_next;
  logic              s1_valid;
  pjb_pkg::res_t     s1_res;
  logic              s1_adv;
  pjb_pkg::res_t     out_res;

  assign cfg_ready = 1'b1;

  // configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      prebuffer_level <= pjb_pkg::PREBUFFER_RST;
      underrun_level  <= pjb_pkg::UNDERRUN_RST;
      grace_periods   <= pjb_pkg::GRACE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pjb_pkg::REG_PREBUFFER: prebuffer_level <= cfg_data;
        pjb_pkg::REG_UNDERRUN:  underrun_level  <= cfg_data;
        pjb_pkg::REG_GRACE:     grace_periods   <= cfg_data[pjb_pkg::GRACE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the read stage moves on when the output register is free
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // command decode and next buffer state
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    gate_next   = gate;
    under_next  = under;
    do_push     = 1'b0;
    do_pull     = 1'b0;
    case (cmd)
      pjb_pkg::CMD_PUSH: begin
        // drop the sample when the store is full
        if (count != pjb_pkg::CNT_W'(pjb_pkg::DEPTH)) begin
          do_push     = 1'b1;
          wr_ptr_next = (wr_ptr == pjb_pkg::PTR_W'(pjb_pkg::DEPTH - 1)) ?
                        '0 : wr_ptr + 1'b1;
          count_next  = count + 1'b1;
        end
      end
      pjb_pkg::CMD_PERIOD: begin
        if (stream_active) begin
          // open the gate once prebuffered
          if (!gate && (pjb_pkg::CMP_W'(count) >=
                        pjb_pkg::CMP_W'(prebuffer_level))) begin
            gate_next  = 1'b1;
            under_next = '0;
          end
          // count underrun periods, close after the grace runs out
          if (gate_next && (pjb_pkg::CMP_W'(count) <
                            pjb_pkg::CMP_W'(underrun_level))) begin
            under_next = under_next + 1'b1;
            if (under_next >= grace_periods) begin
              gate_next  = 1'b0;
              under_next = '0;
            end
          end else if (gate_next) begin
            under_next = '0;
          end
        end
      end
      pjb_pkg::CMD_PULL: begin
        if (stream_active && (gate || (under != '0)) && (count != '0)) begin
          do_pull     = 1'b1;
          rd_ptr_next = (rd_ptr == pjb_pkg::PTR_W'(pjb_pkg::DEPTH - 1)) ?
                        '0 : rd_ptr + 1'b1;
          count_next  = count - 1'b1;
        end
      end
      pjb_pkg::CMD_FLUSH: begin
        wr_ptr_next = '0;
        rd_ptr_next = '0;
        count_next  = '0;
        gate_next   = 1'b0;
        under_next  = '0;
      end
      default: ;
    endcase
    res_next.from_buffer   = do_pull;
    res_next.push_accepted = do_push;
    res_next.fill_level    = pjb_pkg::LEVEL_W'(count_next);
    res_next.playing       = gate_next;
    res_next.grace_count   = under_next;
  end

  // buffer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      gate   <= 1'b0;
      under  <= '0;
    end else if (accept) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
      gate   <= gate_next;
      under  <= under_next;
    end
  end

  // sample store: one command per beat, so a write and a read never share
  // a cycle, and a read of a just-written entry sees the committed data
  always_ff @(posedge clk) begin
    if (accept && do_push) begin
      store[wr_ptr] <= sample_in;
    end
    if (accept && do_pull) begin
      rdata <= store[rd_ptr];
    end
  end

  // read stage: holds result fields while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_res    <= s1_res;
      sample_out <= s1_res.from_buffer ? rdata : '0;
    end
  end

  assign from_buffer   = out_res.from_buffer;
  assign push_accepted = out_res.push_accepted;
  assign fill_level    = out_res.fill_level;
  assign playing       = out_res.playing;
  assign grace_count   = out_res.grace_count;

  // checks

  // input stalls only when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with a free stage");

  // fill count never exceeds the store depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pjb_pkg::CMP_W'(count) <= pjb_pkg::CMP_W'(pjb_pkg::DEPTH))
    else $error("fill count beyond depth");

  // a pending underrun count means the gate is open
  a_under_gate: assert property (@(posedge clk) disable iff (rst)
    (under != '0) |-> gate)
    else $error("underrun count with gate closed");

  // only a pull beat can read from the store
  a_pull_only: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd != pjb_pkg::CMD_PULL)) |=> !s1_res.from_buffer)
    else $error("store read on a non-pull beat");

  // a push into a full store is dropped
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == pjb_pkg::CMD_PUSH) &&
     (count == pjb_pkg::CNT_W'(pjb_pkg::DEPTH))) |=> !s1_res.push_accepted)
    else $error("push stored into a full buffer");

endmodule
